// File: src/rbei_pkg.sv
// Shared types, constants and saturation helpers for the 2D rigid body integrator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rbei_pkg;

	localparam int Q_W       = 32;
	localparam int DEPTH_W   = 31;
	localparam int DRAG_W    = 17;
	localparam int TS_W      = 16;
	localparam int BLK_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 2 * MUL_W;

	// standard gravity, -9.8 in Q16.16
	localparam logic signed [MUL_W-1:0] GRAVITY_Q16 = -33'sd642253;
	localparam logic [DRAG_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [Q_W-1:0]       RST_INV_MASS  = 32'd65536;
	localparam logic [Q_W-1:0]       RST_GRAV_SCL  = 32'd65536;
	localparam logic [TS_W-1:0]      RST_TIME_STEP = 16'd1311;

	// blocked flag bits
	localparam int BLK_LEFT  = 0;
	localparam int BLK_RIGHT = 1;
	localparam int BLK_DOWN  = 2;
	localparam int BLK_UP    = 3;

	typedef enum logic [1:0] {
		REQ_FORCE   = 2'd0,
		REQ_IMPULSE = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_CONTACT = 2'd3
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_MASS  = 3'd0,
		CFG_GRAV_SCL  = 3'd1,
		CFG_DRAG      = 3'd2,
		CFG_GRAV_EN   = 3'd3,
		CFG_KINEMATIC = 3'd4,
		CFG_TIME_STEP = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MA_VX, MA_VY, MA_GRAV, MA_ACC0, MA_ACC1, MA_VEL0, MA_VEL1
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_IMASS, MB_GSCALE, MB_TS, MB_KEEP, MB_DEPTH
	} mul_b_t;

	typedef enum logic [3:0] {
		WD_NONE, WD_ACC0, WD_ACC1, WD_IMP0, WD_IMP1,
		WD_VEL0, WD_VEL1, WD_POS0, WD_POS1
	} wb_dst_t;

	typedef struct packed {
		logic    latch_item;
		mul_a_t  mul_a;
		mul_b_t  mul_b;
		wb_dst_t wb_dst;
		logic    wb_add;     // add to destination, else replace
		logic    wb_clamp;   // zero velocity pointing into a blocked side
		logic    wb_half;    // contact: halve when other body is dynamic
		logic    imp_add;
		logic    clear_ia;
		logic    set_flags;
		logic    load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		req_kind_t kind;
		logic      kinematic;
		logic      apply_grav;
	} ctrl_status_t;

	function automatic logic signed [Q_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = {{(PROD_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi)
			return hi[Q_W-1:0];
		else if (v < lo)
			return lo[Q_W-1:0];
		else
			return v[Q_W-1:0];
	endfunction

	function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [Q_W:0] s;
		s = {a[Q_W-1], a} + {b[Q_W-1], b};
		if (s[Q_W] != s[Q_W-1])
			return s[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
		else
			return s[Q_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: src/rbei_if.sv
// Channel interfaces of the rigid body integrator: item, result and config write.
// Depends on rbei_pkg for field widths.
`default_nettype none

interface rbei_item_if;
	import rbei_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic signed [Q_W-1:0]     vec_x;
	logic signed [Q_W-1:0]     vec_y;
	logic [DEPTH_W-1:0]        contact_depth;
	logic                      other_dynamic;
	logic                      grounded;
	modport source (output valid, req_type, vec_x, vec_y, contact_depth, other_dynamic,
		grounded, input ready);
	modport sink (input valid, req_type, vec_x, vec_y, contact_depth, other_dynamic,
		grounded, output ready);
endinterface

interface rbei_result_if;
	import rbei_pkg::*;
	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] pos_x;
	logic signed [Q_W-1:0] pos_y;
	logic signed [Q_W-1:0] vel_x;
	logic signed [Q_W-1:0] vel_y;
	logic [BLK_W-1:0]      blocked_sides;
	modport source (output valid, pos_x, pos_y, vel_x, vel_y, blocked_sides, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, blocked_sides, output ready);
endinterface

interface rbei_cfg_if;
	import rbei_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [Q_W-1:0]       data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/rbei_ctrl.sv
// Sequencer for the integrator: walks each item through the shared multiplier steps.
// Depends on rbei_pkg; drives rbei_dp through ctrl_cmd_t, reads ctrl_status_t.
`default_nettype none

module rbei_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  rbei_pkg::ctrl_status_t status,
	output rbei_pkg::ctrl_cmd_t   cmd
);
	import rbei_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_F_Y, S_F_W, S_I_Y, S_I_W,
		S_T_AX, S_T_AY, S_T_DX, S_T_DY, S_T_PX, S_T_PY, S_T_PW,
		S_C_Y, S_C_W, S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.latch_item = in_valid && (state_q == S_IDLE);
		cmd.mul_a      = MA_VX;
		cmd.mul_b      = MB_IMASS;
		cmd.wb_dst     = WD_NONE;
		cmd.wb_add     = 1'b0;
		cmd.wb_clamp   = 1'b0;
		cmd.wb_half    = 1'b0;
		cmd.imp_add    = 1'b0;
		cmd.clear_ia   = 1'b0;
		cmd.set_flags  = 1'b0;
		cmd.load_out   = 1'b0;
		case (state_q)
			S_DISP: begin
				case (status.kind)
					REQ_TICK: begin
						cmd.imp_add = !status.kinematic;
						cmd.mul_a   = MA_GRAV;
						cmd.mul_b   = MB_GSCALE;
					end
					REQ_CONTACT: begin
						cmd.mul_a = MA_VX;
						cmd.mul_b = MB_DEPTH;
					end
					default: begin
						cmd.mul_a = MA_VX;
						cmd.mul_b = MB_IMASS;
					end
				endcase
			end
			S_F_Y: begin
				cmd.mul_a  = MA_VY;
				cmd.wb_dst = WD_ACC0;
				cmd.wb_add = 1'b1;
			end
			S_F_W: begin
				cmd.wb_dst = WD_ACC1;
				cmd.wb_add = 1'b1;
			end
			S_I_Y: begin
				cmd.mul_a  = MA_VY;
				cmd.wb_dst = WD_IMP0;
			end
			S_I_W: cmd.wb_dst = WD_IMP1;
			S_T_AX: begin
				cmd.wb_dst = status.apply_grav ? WD_ACC1 : WD_NONE;
				cmd.wb_add = 1'b1;
				cmd.mul_a  = MA_ACC0;
				cmd.mul_b  = MB_TS;
			end
			S_T_AY: begin
				cmd.wb_dst = WD_VEL0;
				cmd.wb_add = 1'b1;
				cmd.mul_a  = MA_ACC1;
				cmd.mul_b  = MB_TS;
			end
			S_T_DX: begin
				cmd.wb_dst = WD_VEL1;
				cmd.wb_add = 1'b1;
				cmd.mul_a  = MA_VEL0;
				cmd.mul_b  = MB_KEEP;
			end
			S_T_DY: begin
				cmd.wb_dst   = WD_VEL0;
				cmd.wb_clamp = 1'b1;
				cmd.mul_a    = MA_VEL1;
				cmd.mul_b    = MB_KEEP;
			end
			S_T_PX: begin
				cmd.wb_dst   = WD_VEL1;
				cmd.wb_clamp = 1'b1;
				cmd.mul_a    = MA_VEL0;
				cmd.mul_b    = MB_TS;
			end
			S_T_PY: begin
				cmd.wb_dst = WD_POS0;
				cmd.wb_add = 1'b1;
				cmd.mul_a  = MA_VEL1;
				cmd.mul_b  = MB_TS;
			end
			S_T_PW: begin
				cmd.wb_dst   = WD_POS1;
				cmd.wb_add   = 1'b1;
				cmd.clear_ia = 1'b1;
			end
			S_C_Y: begin
				cmd.wb_dst  = WD_POS0;
				cmd.wb_add  = 1'b1;
				cmd.wb_half = 1'b1;
				cmd.mul_a   = MA_VY;
				cmd.mul_b   = MB_DEPTH;
			end
			S_C_W: begin
				cmd.wb_dst    = WD_POS1;
				cmd.wb_add    = 1'b1;
				cmd.wb_half   = 1'b1;
				cmd.set_flags = 1'b1;
			end
			S_DONE: cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces one that leaves in the same cycle
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DISP;
				S_DISP: begin
					if (status.kinematic)
						state_q <= S_DONE;
					else begin
						case (status.kind)
							REQ_FORCE:   state_q <= S_F_Y;
							REQ_IMPULSE: state_q <= S_I_Y;
							REQ_TICK:    state_q <= S_T_AX;
							default:     state_q <= S_C_Y;
						endcase
					end
				end
				S_F_Y:  state_q <= S_F_W;
				S_F_W:  state_q <= S_DONE;
				S_I_Y:  state_q <= S_I_W;
				S_I_W:  state_q <= S_DONE;
				S_T_AX: state_q <= S_T_AY;
				S_T_AY: state_q <= S_T_DX;
				S_T_DX: state_q <= S_T_DY;
				S_T_DY: state_q <= S_T_PX;
				S_T_PX: state_q <= S_T_PY;
				S_T_PY: state_q <= S_T_PW;
				S_T_PW: state_q <= S_DONE;
				S_C_Y:  state_q <= S_C_W;
				S_C_W:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/rbei_dp.sv
// Datapath of the integrator: config and body state, latched item, one shared
// 33x33 multiplier with a registered product, saturating writeback, result register.
// Depends on rbei_pkg; controlled by rbei_ctrl.
`default_nettype none

module rbei_dp (
	input  wire                         clk,
	input  wire                         arst_n,
	input  rbei_pkg::ctrl_cmd_t         cmd,
	output rbei_pkg::ctrl_status_t      status,
	input  wire                         cfg_we,
	input  wire [rbei_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [rbei_pkg::Q_W-1:0]     cfg_data,
	input  wire [1:0]                   in_req_type,
	input  wire signed [rbei_pkg::Q_W-1:0] in_vec_x,
	input  wire signed [rbei_pkg::Q_W-1:0] in_vec_y,
	input  wire [rbei_pkg::DEPTH_W-1:0] in_depth,
	input  wire                         in_other_dynamic,
	input  wire                         in_grounded,
	output logic signed [rbei_pkg::Q_W-1:0] out_pos_x,
	output logic signed [rbei_pkg::Q_W-1:0] out_pos_y,
	output logic signed [rbei_pkg::Q_W-1:0] out_vel_x,
	output logic signed [rbei_pkg::Q_W-1:0] out_vel_y,
	output logic [rbei_pkg::BLK_W-1:0]  out_blocked
);
	import rbei_pkg::*;

	// configuration
	logic [Q_W-1:0]        inv_mass_q;
	logic signed [Q_W-1:0] grav_scl_q;
	logic [DRAG_W-1:0]     drag_q;
	logic                  grav_en_q;
	logic                  kinematic_q;
	logic [TS_W-1:0]       time_step_q;

	// body state
	logic signed [Q_W-1:0] pos0_q, pos1_q, vel0_q, vel1_q;
	logic signed [Q_W-1:0] acc0_q, acc1_q, imp0_q, imp1_q;
	logic [BLK_W-1:0]      blk_q;

	// latched item
	logic [1:0]            kind_q;
	logic signed [Q_W-1:0] vx_q, vy_q;
	logic [DEPTH_W-1:0]    depth_q;
	logic                  other_q, grounded_q;

	logic signed [MUL_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] prod_shr;
	logic signed [Q_W-1:0]    prod_sat, wb_cur, wb_val;
	logic [DRAG_W-1:0]        keep;

	assign status.kind       = req_kind_t'(kind_q);
	assign status.kinematic  = kinematic_q;
	assign status.apply_grav = grav_en_q && !grounded_q;

	// drag of one or more keeps nothing
	assign keep = drag_q[DRAG_W-1] ? '0 : ONE_Q16 - drag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q  <= RST_INV_MASS;
			grav_scl_q  <= RST_GRAV_SCL;
			drag_q      <= '0;
			grav_en_q   <= 1'b1;
			kinematic_q <= 1'b0;
			time_step_q <= RST_TIME_STEP;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INV_MASS:  inv_mass_q  <= cfg_data;
				CFG_GRAV_SCL:  grav_scl_q  <= cfg_data;
				CFG_DRAG:      drag_q      <= cfg_data[DRAG_W-1:0];
				CFG_GRAV_EN:   grav_en_q   <= cfg_data[0];
				CFG_KINEMATIC: kinematic_q <= cfg_data[0];
				CFG_TIME_STEP: time_step_q <= cfg_data[TS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			kind_q     <= in_req_type;
			vx_q       <= in_vec_x;
			vy_q       <= in_vec_y;
			depth_q    <= in_depth;
			other_q    <= in_other_dynamic;
			grounded_q <= in_grounded;
		end
	end

	always_comb begin
		case (cmd.mul_a)
			MA_VX:   op_a = {vx_q[Q_W-1], vx_q};
			MA_VY:   op_a = {vy_q[Q_W-1], vy_q};
			MA_GRAV: op_a = GRAVITY_Q16;
			MA_ACC0: op_a = {acc0_q[Q_W-1], acc0_q};
			MA_ACC1: op_a = {acc1_q[Q_W-1], acc1_q};
			MA_VEL0: op_a = {vel0_q[Q_W-1], vel0_q};
			MA_VEL1: op_a = {vel1_q[Q_W-1], vel1_q};
			default: op_a = '0;
		endcase
		case (cmd.mul_b)
			MB_IMASS:  op_b = {1'b0, inv_mass_q};
			MB_GSCALE: op_b = {grav_scl_q[Q_W-1], grav_scl_q};
			MB_TS:     op_b = {{(MUL_W-TS_W){1'b0}}, time_step_q};
			MB_KEEP:   op_b = {{(MUL_W-DRAG_W){1'b0}}, keep};
			MB_DEPTH:  op_b = {{(MUL_W-DEPTH_W){1'b0}}, depth_q};
			default:   op_b = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	// arithmetic shift gives floor rounding
	assign prod_shr = (cmd.wb_half && other_q) ? (prod_q >>> 17) : (prod_q >>> 16);
	assign prod_sat = sat_prod(prod_shr);

	always_comb begin
		case (cmd.wb_dst)
			WD_ACC0: wb_cur = acc0_q;
			WD_ACC1: wb_cur = acc1_q;
			WD_IMP0: wb_cur = imp0_q;
			WD_IMP1: wb_cur = imp1_q;
			WD_VEL0: wb_cur = vel0_q;
			WD_VEL1: wb_cur = vel1_q;
			WD_POS0: wb_cur = pos0_q;
			WD_POS1: wb_cur = pos1_q;
			default: wb_cur = '0;
		endcase
		wb_val = cmd.wb_add ? sat_add(wb_cur, prod_sat) : prod_sat;
		if (cmd.wb_clamp) begin
			if (cmd.wb_dst == WD_VEL0) begin
				if ((blk_q[BLK_LEFT] && wb_val < 0) || (blk_q[BLK_RIGHT] && wb_val > 0))
					wb_val = '0;
			end else begin
				if ((blk_q[BLK_DOWN] && wb_val < 0) || (blk_q[BLK_UP] && wb_val > 0))
					wb_val = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos0_q <= '0;
			pos1_q <= '0;
			vel0_q <= '0;
			vel1_q <= '0;
			acc0_q <= '0;
			acc1_q <= '0;
			imp0_q <= '0;
			imp1_q <= '0;
			blk_q  <= '0;
		end else begin
			if (cmd.imp_add) begin
				vel0_q <= sat_add(vel0_q, imp0_q);
				vel1_q <= sat_add(vel1_q, imp1_q);
			end
			case (cmd.wb_dst)
				WD_ACC0: acc0_q <= wb_val;
				WD_ACC1: acc1_q <= wb_val;
				WD_IMP0: imp0_q <= wb_val;
				WD_IMP1: imp1_q <= wb_val;
				WD_VEL0: vel0_q <= wb_val;
				WD_VEL1: vel1_q <= wb_val;
				WD_POS0: pos0_q <= wb_val;
				WD_POS1: pos1_q <= wb_val;
				default: ;
			endcase
			if (cmd.clear_ia) begin
				acc0_q <= '0;
				acc1_q <= '0;
				imp0_q <= '0;
				imp1_q <= '0;
			end
			if (cmd.set_flags) begin
				blk_q[BLK_LEFT]  <= blk_q[BLK_LEFT]  | (!vx_q[Q_W-1] && vx_q != 0);
				blk_q[BLK_RIGHT] <= blk_q[BLK_RIGHT] | vx_q[Q_W-1];
				blk_q[BLK_DOWN]  <= blk_q[BLK_DOWN]  | (!vy_q[Q_W-1] && vy_q != 0);
				blk_q[BLK_UP]    <= blk_q[BLK_UP]    | vy_q[Q_W-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pos_x   <= pos0_q;
			out_pos_y   <= pos1_q;
			out_vel_x   <= vel0_q;
			out_vel_y   <= vel1_q;
			out_blocked <= blk_q;
		end
	end

endmodule

`default_nettype wire

// File: src/rigid_body_euler_integrator_2d_unit.sv
// Top level of the 2D rigid body semi-implicit Euler integrator.
// Depends on rbei_pkg, rbei_if, rbei_ctrl and rbei_dp.
//
//   channel  | modport | payload                                      | handshake
//   ---------+---------+----------------------------------------------+------------
//   item     | sink    | req_type, vec_x, vec_y, contact_depth,       | valid/ready
//            |         | other_dynamic, grounded                      |
//   result   | source  | pos_x, pos_y, vel_x, vel_y, blocked_sides    | valid/ready
//   cfg      | sink    | index, data                                  | ready always 1
//
// One item in flight: each request walks its own sequence of steps through the single
// shared multiplier with its registered product, and any item on a kinematic body
// skips those steps and goes straight to the result.
// The result register holds a finished item while the next one is accepted.
// Reset is asynchronous, active low; it restores config defaults and zeroes the body.
`default_nettype none

module rigid_body_euler_integrator_2d_unit (
	input  wire           clk,
	input  wire           arst_n,
	rbei_item_if.sink     item,
	rbei_result_if.source result,
	rbei_cfg_if.sink      cfg
);
	import rbei_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	assign cfg.ready = 1'b1;

	rbei_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rbei_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.in_req_type      (item.req_type),
		.in_vec_x         (item.vec_x),
		.in_vec_y         (item.vec_y),
		.in_depth         (item.contact_depth),
		.in_other_dynamic (item.other_dynamic),
		.in_grounded      (item.grounded),
		.out_pos_x        (result.pos_x),
		.out_pos_y        (result.pos_y),
		.out_vel_x        (result.vel_x),
		.out_vel_y        (result.vel_y),
		.out_blocked      (result.blocked_sides)
	);

endmodule

`default_nettype wire

// File: src/rbei_checker.sv
// Port-level checks for the rigid body integrator, bound to the top level.
// Depends on rbei_pkg for widths; watches the top level's channel signals only.
`default_nettype none

module rbei_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            in_valid,
	input wire                            in_ready,
	input wire                            out_valid,
	input wire                            out_ready,
	input wire                            cfg_valid,
	input wire                            cfg_ready,
	input wire [rbei_pkg::Q_W-1:0]        pos_x,
	input wire [rbei_pkg::Q_W-1:0]        pos_y,
	input wire [rbei_pkg::Q_W-1:0]        vel_x,
	input wire [rbei_pkg::Q_W-1:0]        vel_y,
	input wire [rbei_pkg::BLK_W-1:0]      blocked
);
	import rbei_pkg::*;

	// one item at a time: no second accept right after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted back to back");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(vel_x) && $stable(vel_y) && $stable(blocked)))
		else $error("stalled result changed");

	// blocked flags only ever get set
	a_blk_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $past(out_valid)) |-> ((blocked & $past(blocked)) == $past(blocked)))
		else $error("blocked flag cleared");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind rigid_body_euler_integrator_2d_unit rbei_checker u_rbei_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.pos_x     (result.pos_x),
	.pos_y     (result.pos_y),
	.vel_x     (result.vel_x),
	.vel_y     (result.vel_y),
	.blocked   (result.blocked_sides)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for rigid_body_euler_integrator_2d_unit.
// Depends on rbei_pkg and rbei_if; it predicts each body state in-line and checks every result.
// Directed items cover each request and the corner cases; random traffic then runs under three idle mixes.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rbei_pkg::*;

	localparam int FRAC = 16;
	localparam int Q_ONE = 65536;
	localparam int Q_MAX = 32'sh7fff_ffff;
	localparam int Q_MIN = 32'sh8000_0000;
	localparam int DRAIN_CYCLES = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic signed [131:0] PROD_MAX = Q_MAX;
	localparam logic signed [131:0] PROD_MIN = Q_MIN;

	typedef struct {
		req_kind_t          kind;
		int                 vx;
		int                 vy;
		logic [DEPTH_W-1:0] depth;
		logic               other_dyn;
		logic               grounded;
	} body_req_t;

	typedef struct {
		int               pos_x;
		int               pos_y;
		int               vel_x;
		int               vel_y;
		logic [BLK_W-1:0] blocked;
	} body_state_t;

	logic clk;
	logic arst_n;

	rbei_item_if   item_ch();
	rbei_result_if result_ch();
	rbei_cfg_if    cfg_ch();

	rigid_body_euler_integrator_2d_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// predicted register file and body state, starting at reset values
	logic [Q_W-1:0]    reg_inv_mass   = RST_INV_MASS;
	int                reg_grav_scale = RST_GRAV_SCL;
	logic [DRAG_W-1:0] reg_drag       = '0;
	logic              reg_grav_en    = 1'b1;
	logic              reg_kinematic  = 1'b0;
	logic [TS_W-1:0]   reg_time_step  = RST_TIME_STEP;

	int               body_pos[2] = '{0, 0};
	int               body_vel[2] = '{0, 0};
	int               body_acc[2] = '{0, 0};
	int               body_imp[2] = '{0, 0};
	logic [BLK_W-1:0] body_blocked = '0;

	body_state_t expected_states[$];
	int          errors_seen = 0;
	int          send_idle_pct = 21;
	int          recv_idle_pct = 48;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	// exact product shifted right with floor rounding, saturated to 32 bits
	function automatic int scaled_product(input logic signed [65:0] a,
			input logic signed [65:0] b, input int shift);
		logic signed [131:0] p;
		p = a * b;
		p = p >>> shift;
		if (p > PROD_MAX)
			return Q_MAX;
		if (p < PROD_MIN)
			return Q_MIN;
		return p[31:0];
	endfunction

	function automatic int clamp_sum(input int a, input int b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(Q_MAX))
			return Q_MAX;
		if (s < longint'(Q_MIN))
			return Q_MIN;
		return int'(s);
	endfunction

	function automatic body_state_t advance_body(input body_req_t r);
		body_state_t s;
		int keep;
		int shift;
		if (!reg_kinematic) begin
			case (r.kind)
			REQ_FORCE: begin
				body_acc[0] = clamp_sum(body_acc[0], scaled_product(r.vx, reg_inv_mass, FRAC));
				body_acc[1] = clamp_sum(body_acc[1], scaled_product(r.vy, reg_inv_mass, FRAC));
			end
			REQ_IMPULSE: begin
				body_imp[0] = scaled_product(r.vx, reg_inv_mass, FRAC);
				body_imp[1] = scaled_product(r.vy, reg_inv_mass, FRAC);
			end
			REQ_TICK: begin
				// drag above one acts as full loss
				keep = int'(ONE_Q16) - ((reg_drag > ONE_Q16) ? int'(ONE_Q16) : int'(reg_drag));
				for (int i = 0; i < 2; i++)
					body_vel[i] = clamp_sum(body_vel[i], body_imp[i]);
				if (reg_grav_en && !r.grounded)
					body_acc[1] = clamp_sum(body_acc[1],
						scaled_product(GRAVITY_Q16, reg_grav_scale, FRAC));
				for (int i = 0; i < 2; i++) begin
					body_vel[i] = clamp_sum(body_vel[i],
						scaled_product(body_acc[i], reg_time_step, FRAC));
					body_vel[i] = scaled_product(body_vel[i], keep, FRAC);
				end
				if (body_blocked[BLK_LEFT] && body_vel[0] < 0)
					body_vel[0] = 0;
				if (body_blocked[BLK_RIGHT] && body_vel[0] > 0)
					body_vel[0] = 0;
				if (body_blocked[BLK_DOWN] && body_vel[1] < 0)
					body_vel[1] = 0;
				if (body_blocked[BLK_UP] && body_vel[1] > 0)
					body_vel[1] = 0;
				for (int i = 0; i < 2; i++) begin
					body_pos[i] = clamp_sum(body_pos[i],
						scaled_product(body_vel[i], reg_time_step, FRAC));
					body_imp[i] = 0;
					body_acc[i] = 0;
				end
			end
			REQ_CONTACT: begin
				shift = r.other_dyn ? FRAC + 1 : FRAC;
				body_pos[0] = clamp_sum(body_pos[0], scaled_product(r.vx, r.depth, shift));
				body_pos[1] = clamp_sum(body_pos[1], scaled_product(r.vy, r.depth, shift));
				if (r.vx > 0)
					body_blocked[BLK_LEFT] = 1'b1;
				else if (r.vx < 0)
					body_blocked[BLK_RIGHT] = 1'b1;
				if (r.vy > 0)
					body_blocked[BLK_DOWN] = 1'b1;
				else if (r.vy < 0)
					body_blocked[BLK_UP] = 1'b1;
			end
			default: ;
			endcase
		end
		s.pos_x = body_pos[0];
		s.pos_y = body_pos[1];
		s.vel_x = body_vel[0];
		s.vel_y = body_vel[1];
		s.blocked = body_blocked;
		return s;
	endfunction

	function automatic body_req_t mk_req(input req_kind_t kind, input int vx, input int vy,
			input logic [DEPTH_W-1:0] depth, input logic other_dyn, input logic grounded);
		body_req_t r;
		r.kind = kind;
		r.vx = vx;
		r.vy = vy;
		r.depth = depth;
		r.other_dyn = other_dyn;
		r.grounded = grounded;
		return r;
	endfunction

	function automatic int rand_q();
		case ($urandom_range(0, 9))
		0: return $urandom;
		1: return Q_MAX;
		2: return Q_MIN;
		3: return 0;
		default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
		endcase
	endfunction

	function automatic body_req_t rand_req();
		body_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.kind = (pick < 30) ? REQ_FORCE : (pick < 45) ? REQ_IMPULSE :
			(pick < 92) ? REQ_TICK : REQ_CONTACT;
		r.vx = rand_q();
		r.vy = rand_q();
		r.depth = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 17));
		r.other_dyn = $urandom_range(0, 1);
		r.grounded = $urandom_range(0, 1);
		// most contacts push out along one positive axis; flags never clear, so keep them rare
		if (r.kind == REQ_CONTACT && $urandom_range(0, 9) != 0) begin
			if ($urandom_range(0, 1)) begin
				r.vx = 0;
				r.vy = $urandom_range(1, Q_ONE);
			end else begin
				r.vx = $urandom_range(1, Q_ONE);
				r.vy = 0;
			end
		end
		return r;
	endfunction

	task automatic send_item(input body_req_t r);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		item_ch.valid         <= 1'b1;
		item_ch.req_type      <= r.kind;
		item_ch.vec_x         <= r.vx;
		item_ch.vec_y         <= r.vy;
		item_ch.contact_depth <= r.depth;
		item_ch.other_dynamic <= r.other_dyn;
		item_ch.grounded      <= r.grounded;
		do @(posedge clk); while (!item_ch.ready);
		expected_states.push_back(advance_body(r));
	endtask

	// stop sending and let every outstanding item finish
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (expected_states.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
		CFG_INV_MASS:  reg_inv_mass = data;
		CFG_GRAV_SCL:  reg_grav_scale = data;
		CFG_DRAG:      reg_drag = data[DRAG_W-1:0];
		CFG_GRAV_EN:   reg_grav_en = data[0];
		CFG_KINEMATIC: reg_kinematic = data[0];
		CFG_TIME_STEP: reg_time_step = data[TS_W-1:0];
		default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [Q_W-1:0] inv_mass, input int grav_scale,
			input logic [Q_W-1:0] drag_word, input logic [Q_W-1:0] enable_word,
			input logic [Q_W-1:0] kinematic_word, input logic [Q_W-1:0] step_word);
		write_reg(CFG_INV_MASS, inv_mass);
		write_reg(CFG_GRAV_SCL, grav_scale);
		write_reg(CFG_DRAG, drag_word);
		write_reg(CFG_GRAV_EN, enable_word);
		write_reg(CFG_KINEMATIC, kinematic_word);
		write_reg(CFG_TIME_STEP, step_word);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors_seen++;
		end
	endfunction

	always @(posedge clk) begin
		body_state_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_states.size() == 0) begin
				$error("result item with no expected state pending");
				errors_seen++;
			end else begin
				want = expected_states.pop_front();
				check_field("pos_x", want.pos_x, result_ch.pos_x);
				check_field("pos_y", want.pos_y, result_ch.pos_y);
				check_field("vel_x", want.vel_x, result_ch.vel_x);
				check_field("vel_y", want.vel_y, result_ch.vel_y);
				check_field("blocked_sides", want.blocked, result_ch.blocked_sides);
			end
		end
	end

	task automatic test_each_request();
		send_item(mk_req(REQ_FORCE, 3 * Q_ONE, -Q_ONE, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_IMPULSE, Q_ONE / 2, 2 * Q_ONE, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_TICK, 0, 0, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_TICK, 0, 0, '0, 1'b0, 1'b1));
		// zero normal moves nothing and sets no flag
		send_item(mk_req(REQ_CONTACT, 0, 0, '1, 1'b0, 1'b0));
		send_item(mk_req(REQ_CONTACT, Q_ONE, 0, 31'(Q_ONE / 4), 1'b1, 1'b0));
		send_item(mk_req(REQ_TICK, 0, 0, '0, 1'b0, 1'b0));
	endtask

	task automatic test_field_extremes();
		send_item(mk_req(REQ_FORCE, Q_MAX, Q_MIN, '1, 1'b1, 1'b1));
		send_item(mk_req(REQ_IMPULSE, Q_MIN, Q_MAX, '0, 1'b1, 1'b0));
		send_item(mk_req(REQ_TICK, Q_MIN, Q_MAX, '1, 1'b0, 1'b0));
		send_item(mk_req(REQ_CONTACT, 0, Q_ONE, '1, 1'b0, 1'b1));
	endtask

	task automatic test_config_extremes();
		wait_idle();
		// unused indexes must leave every register alone
		write_reg(CFG_SPARE_LO, 32'hffff_ffff);
		write_reg(CFG_SPARE_HI, 32'h0000_0000);
		// drag above one, gravity off by bit 0 only, zero time step
		apply_settings(32'hffff_ffff, Q_MIN, 32'hffff_ffff, 32'hffff_fffe, 32'h0, 32'h0);
		send_item(mk_req(REQ_FORCE, -Q_ONE, Q_ONE, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_IMPULSE, 1, -1, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_TICK, 0, 0, '0, 1'b0, 1'b0));
		wait_idle();
		apply_settings(32'h0, Q_MAX, Q_ONE, 32'h1, 32'h0, 32'hffff);
		send_item(mk_req(REQ_FORCE, Q_MAX, Q_MAX, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_IMPULSE, Q_MAX, Q_MIN, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_TICK, 0, 0, '0, 1'b0, 1'b0));
		wait_idle();
		apply_settings(RST_INV_MASS, RST_GRAV_SCL, 32'd0, 32'h1, 32'h0, 32'hffff);
		send_item(mk_req(REQ_TICK, 0, 0, '0, 1'b0, 1'b0));
	endtask

	task automatic test_kinematic();
		wait_idle();
		apply_settings(RST_INV_MASS, RST_GRAV_SCL, 32'd0, 32'h1, 32'h1, RST_TIME_STEP);
		send_item(mk_req(REQ_FORCE, Q_ONE, Q_ONE, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_IMPULSE, Q_ONE, Q_ONE, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_TICK, 0, 0, '0, 1'b0, 1'b0));
		send_item(mk_req(REQ_CONTACT, -Q_ONE, -Q_ONE, 31'(Q_ONE), 1'b0, 1'b0));
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 21;
		recv_idle_pct = 48;
		wait_idle();
		apply_settings(32'h0002_0000, Q_ONE, 32'd1000, 32'h1, 32'h0, RST_TIME_STEP);
		repeat (190) send_item(rand_req());

		send_idle_pct = 48;
		recv_idle_pct = 21;
		wait_idle();
		apply_settings(32'h0000_8000, -3 * Q_ONE, 32'd0, 32'h1, 32'h0, 32'hffff);
		repeat (180) send_item(rand_req());

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (3) begin
			wait_idle();
			apply_settings($urandom_range(0, 32'h40000),
				int'($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE,
				$urandom_range(0, 70000), $urandom, 32'h0, $urandom_range(0, 16'hffff));
			repeat (60) send_item(rand_req());
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.req_type      = REQ_FORCE;
		item_ch.vec_x         = '0;
		item_ch.vec_y         = '0;
		item_ch.contact_depth = '0;
		item_ch.other_dynamic = 1'b0;
		item_ch.grounded      = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = CFG_INV_MASS;
		cfg_ch.data           = '0;
		result_ch.ready       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_each_request();
		test_field_extremes();
		test_config_extremes();
		test_kinematic();
		test_random_traffic();
		wait_idle();

		if (errors_seen == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
